/* hw/rtl/ijce_pkg.sv */
// Package for the intake jam and color eject controller.
// Holds the tick constants, item layouts, mode and register codes, and drive helpers.
// No dependencies.
package ijce_pkg;

  localparam int unsigned TICK_MS     = 3;
  localparam int unsigned SPEED_LIMIT = 1000;

  localparam int unsigned TIMER_W = 9;
  localparam int unsigned STALL_W = 7;

  localparam logic [TIMER_W-1:0] TICK_T           = TIMER_W'(TICK_MS);
  localparam logic [STALL_W-1:0] TICK_S           = STALL_W'(TICK_MS);
  localparam logic [TIMER_W-1:0] STARTUP_GRACE_MS = 9'd150;
  localparam logic [TIMER_W-1:0] RECOVER_GRACE_MS = 9'd100;
  localparam logic [TIMER_W-1:0] EJECT_MS         = 9'd150;
  localparam logic [TIMER_W-1:0] REVERSE_MS       = 9'd100;
  localparam logic [STALL_W-1:0] STALL_LIMIT_MS   = 7'd50;

  localparam logic [7:0] PROX_MIN      = 8'd40;
  localparam logic [8:0] HUE_RED_LO    = 9'd30;
  localparam logic [8:0] HUE_RED_HI    = 9'd340;
  localparam logic [8:0] HUE_BLUE_LO   = 9'd120;
  localparam logic [8:0] HUE_BLUE_HI   = 9'd270;

  localparam logic signed [11:0] SPEED_MAX   = 12'(SPEED_LIMIT);
  localparam logic signed [11:0] SPEED_MIN   = -12'(SPEED_LIMIT);
  localparam logic signed [11:0] REV_SPEED   = 12'sd100;
  localparam logic signed [19:0] MV_PER_UNIT = 20'sd120;
  localparam logic signed [19:0] MV_SAT_HI   = 20'sd131071;
  localparam logic signed [19:0] MV_SAT_LO   = -20'sd131071;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_EJECT   = 2'd1,
    MODE_REVERSE = 2'd2
  } drive_mode_e;

  typedef enum logic [1:0] {
    CFG_COLOR_SORT  = 2'd0,
    CFG_KEEP_RED    = 2'd1,
    CFG_JAM_RECOVER = 2'd2
  } cfg_reg_e;

  // Packed from the top bit down; the first field sits in the highest bits.
  typedef struct packed {
    logic              sensor_present;
    logic [7:0]        proximity;
    logic [8:0]        hue_deg;
    logic signed [10:0] bottom_velocity;
    logic signed [10:0] top_velocity;
    logic              mid_goal_mode;
    logic              unloading_mode;
    logic signed [11:0] cmd_power;
    logic signed [11:0] bottom_cmd_speed;
    logic signed [11:0] top_cmd_speed;
  } in_item_t;

  typedef struct packed {
    drive_mode_e        drive_mode;
    logic               descore_valve;
    logic signed [17:0] bottom_drive_mv;
    logic signed [17:0] top_drive_mv;
  } out_item_t;

  function automatic logic [TIMER_W-1:0] dec_timer(input logic [TIMER_W-1:0] t);
    return (t < TICK_T) ? '0 : t - TICK_T;
  endfunction

  function automatic logic is_stalled(input logic signed [11:0] spd,
                                      input logic signed [10:0] vel);
    logic signed [15:0] v10;
    logic signed [15:0] s16;
    v10 = (16'(vel) <<< 3) + (16'(vel) <<< 1);
    s16 = 16'(spd);
    if (spd > 12'sd0) return v10 < s16;
    if (spd < 12'sd0) return v10 > s16;
    return 1'b0;
  endfunction

  function automatic logic signed [17:0] drive_mv(input logic signed [11:0] spd);
    logic signed [11:0] c;
    logic signed [19:0] p;
    c = spd;
    if (spd > SPEED_MAX) c = SPEED_MAX;
    if (spd < SPEED_MIN) c = SPEED_MIN;
    p = 20'(c) * MV_PER_UNIT;
    if (p > MV_SAT_HI) p = MV_SAT_HI;
    if (p < MV_SAT_LO) p = MV_SAT_LO;
    return 18'(p);
  endfunction

  function automatic logic signed [11:0] reverse_speed(input logic signed [11:0] spd);
    if (spd > 12'sd0) return -REV_SPEED;
    if (spd < 12'sd0) return REV_SPEED;
    return 12'sd0;
  endfunction

endpackage

/* hw/rtl/intake_jam_and_color_eject_control.sv */
// Intake roller controller: jam recovery and wrong-color ejection, one transaction per tick.
// Depends on ijce_pkg.
//
// Each input transaction is one control tick. It is held in an input register, evaluated
// combinationally against the timers, stall accumulator and previous power, and the drive
// command lands in an output register. Sustained rate is one tick per clock cycle while the
// output is not back-pressured; a result passes through the input and output registers.
// Throughput is set by the single state update per tick and by output back-pressure.
// Configuration writes take effect on the next tick evaluated.
module intake_jam_and_color_eject_control (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // top_cmd_speed, bottom_cmd_speed, cmd_power, unloading_mode, mid_goal_mode,
  // top_velocity, bottom_velocity, hue_deg, proximity, sensor_present, zero pad
  input  logic [ijce_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // top_drive_mv, bottom_drive_mv, descore_valve, drive_mode, zero pad
  output logic [ijce_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic                              cfg_wdata_i
);
  import ijce_pkg::*;

  logic                 color_en_q, keep_red_q, jam_en_q;
  logic                 in_v_q, out_v_q;
  in_item_t             in_q;
  out_item_t            out_q, out_d;
  logic [TIMER_W-1:0]   startup_q, startup_d, eject_q, eject_d, reverse_q, reverse_d;
  logic [STALL_W-1:0]   stall_q, stall_d;
  logic signed [11:0]   last_power_q;
  logic                 valve_q, valve_d;
  logic                 advance, accept;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_en_q <= 1'b1;
      keep_red_q <= 1'b1;
      jam_en_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_COLOR_SORT:  color_en_q <= cfg_wdata_i;
        CFG_KEEP_RED:    keep_red_q <= cfg_wdata_i;
        CFG_JAM_RECOVER: jam_en_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (accept) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    end
  end

  always_comb begin
    logic red, blue, wrong;
    startup_d = startup_q;
    eject_d   = eject_q;
    reverse_d = reverse_q;
    stall_d   = stall_q;
    valve_d   = valve_q;
    red   = (in_q.hue_deg < HUE_RED_LO) || (in_q.hue_deg > HUE_RED_HI);
    blue  = (in_q.hue_deg > HUE_BLUE_LO) && (in_q.hue_deg < HUE_BLUE_HI);
    wrong = (red && !keep_red_q) || (blue && keep_red_q);

    if (startup_q == '0) begin
      if (color_en_q && !in_q.unloading_mode && in_q.proximity >= PROX_MIN &&
          in_q.sensor_present && wrong) begin
        eject_d = EJECT_MS;
      end
      if (jam_en_q) begin
        if (reverse_q == '0 && (is_stalled(in_q.top_cmd_speed, in_q.top_velocity) ||
            is_stalled(in_q.bottom_cmd_speed, in_q.bottom_velocity))) begin
          stall_d = stall_q + TICK_S;
        end else begin
          stall_d = '0;
        end
        if (stall_d > STALL_LIMIT_MS) begin
          reverse_d = REVERSE_MS;
          stall_d   = '0;
        end
      end
    end else begin
      startup_d = dec_timer(startup_q);
    end

    if (last_power_q == 12'sd0 && in_q.cmd_power > 12'sd0) begin
      startup_d = STARTUP_GRACE_MS;
    end

    if (eject_d != '0) begin
      reverse_d              = TIMER_W'(1);
      startup_d              = '0;
      eject_d                = dec_timer(eject_d);
      out_d.top_drive_mv     = drive_mv(SPEED_MAX);
      out_d.bottom_drive_mv  = drive_mv(in_q.bottom_cmd_speed);
      out_d.drive_mode       = MODE_EJECT;
    end else if (reverse_d != '0) begin
      startup_d              = RECOVER_GRACE_MS;
      reverse_d              = dec_timer(reverse_d);
      out_d.top_drive_mv     = drive_mv(reverse_speed(in_q.top_cmd_speed));
      out_d.bottom_drive_mv  = drive_mv(reverse_speed(in_q.bottom_cmd_speed));
      out_d.drive_mode       = MODE_REVERSE;
    end else begin
      out_d.top_drive_mv     = drive_mv(in_q.top_cmd_speed);
      out_d.bottom_drive_mv  = drive_mv(in_q.bottom_cmd_speed);
      valve_d                = in_q.mid_goal_mode;
      out_d.drive_mode       = MODE_NORMAL;
    end
    out_d.descore_valve = valve_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_q    <= '0;
      eject_q      <= '0;
      reverse_q    <= '0;
      stall_q      <= '0;
      last_power_q <= '0;
      valve_q      <= 1'b0;
    end else if (advance) begin
      startup_q    <= startup_d;
      eject_q      <= eject_d;
      reverse_q    <= reverse_d;
      stall_q      <= stall_d;
      last_power_q <= in_q.cmd_power;
      valve_q      <= valve_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  a_stall_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_q <= STALL_LIMIT_MS)
    else $error("stall accumulator above limit");

  a_eject_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eject_q <= EJECT_MS && reverse_q <= REVERSE_MS)
    else $error("eject or reverse timer out of range");

  a_eject_then_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && out_d.drive_mode == MODE_EJECT) |=> (reverse_q == TIMER_W'(1)
      && startup_q == '0))
    else $error("eject tick did not arm one reverse tick");

  a_reverse_grace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && out_d.drive_mode == MODE_REVERSE) |=> startup_q == RECOVER_GRACE_MS)
    else $error("reverse tick did not set recovery grace");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_v_q && out_v_q && !m_axis_tready))
    else $error("input stalled while a stage was free");

endmodule

/* test/tb_top.sv */
// Testbench for intake_jam_and_color_eject_control: directed and random control ticks.
// A scoreboard class predicts each drive command and checks every output transaction.
// Depends on ijce_pkg and the controller RTL.
module tb_top;
  import ijce_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int TICK           = 3;
  localparam int SPD_LIM        = 1000;
  localparam int MV_SCALE       = 120;
  localparam int MV_CAP         = 131071;
  localparam int PROX_NEAR      = 40;
  localparam int HUE_RED_BELOW  = 30;
  localparam int HUE_RED_ABOVE  = 340;
  localparam int HUE_BLUE_ABOVE = 120;
  localparam int HUE_BLUE_BELOW = 270;
  localparam int STALL_MAX      = 50;
  localparam int EJECT_HOLD     = 150;
  localparam int REVERSE_HOLD   = 100;
  localparam int START_GRACE    = 150;
  localparam int RECOVER_GRACE  = 100;
  localparam int REV_CMD        = 100;
  localparam int PHASE_TICKS    = 265;
  localparam int NUM_PHASES     = 7;
  localparam int QUIET_LIMIT    = 2000;
  localparam int REPORT_MAX     = 10;

  // {color_sort_enable, keep_red, jam_recover_enable} per phase, phase 0 in the low bits
  localparam logic [NUM_PHASES-1:0][2:0] CFG_PLAN =
    {3'b001, 3'b100, 3'b111, 3'b010, 3'b101, 3'b000, 3'b111};

  typedef enum int {SEG_STALL, SEG_RUN, SEG_COLOR, SEG_POWER_UP, SEG_NOISE} segment_e;

  class roller_drive_tracker;
    logic               sort_en, red_keep, jam_en;
    logic [8:0]         grace_ms, eject_ms, reverse_ms;
    logic [6:0]         stall_ms;
    logic signed [11:0] prev_power;
    logic               valve;
    out_item_t          pending_drives[$];
    int                 mismatches;
    int                 drives_seen;

    function new();
      sort_en    = 1'b1;
      red_keep   = 1'b1;
      jam_en     = 1'b1;
      grace_ms   = '0;
      eject_ms   = '0;
      reverse_ms = '0;
      stall_ms   = '0;
      prev_power = '0;
      valve      = 1'b0;
      mismatches = 0;
      drives_seen = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic val);
      case (idx)
        CFG_COLOR_SORT:  sort_en = val;
        CFG_KEEP_RED:    red_keep = val;
        CFG_JAM_RECOVER: jam_en = val;
        default: ;
      endcase
    endfunction

    function logic [8:0] tick_down(logic [8:0] t);
      return (t < TICK) ? 9'd0 : t - 9'(TICK);
    endfunction

    function bit lagging(logic signed [11:0] spd, logic signed [10:0] vel);
      int s, v10;
      s = spd;
      v10 = 10 * vel;
      if (s > 0) return v10 < s;
      if (s < 0) return v10 > s;
      return 1'b0;
    endfunction

    function logic signed [17:0] to_mv(int spd);
      int c, mv;
      c = spd;
      if (c > SPD_LIM) c = SPD_LIM;
      if (c < -SPD_LIM) c = -SPD_LIM;
      mv = c * MV_SCALE;
      if (mv > MV_CAP) mv = MV_CAP;
      if (mv < -MV_CAP) mv = -MV_CAP;
      return 18'(mv);
    endfunction

    function int back_off(logic signed [11:0] spd);
      if (spd > 0) return -REV_CMD;
      if (spd < 0) return REV_CMD;
      return 0;
    endfunction

    function void take_tick(in_item_t t);
      out_item_t want;
      bit red, blue;
      if (grace_ms == 0) begin
        if (sort_en && !t.unloading_mode && t.proximity >= PROX_NEAR && t.sensor_present) begin
          red  = t.hue_deg < HUE_RED_BELOW || t.hue_deg > HUE_RED_ABOVE;
          blue = t.hue_deg > HUE_BLUE_ABOVE && t.hue_deg < HUE_BLUE_BELOW;
          if ((red && !red_keep) || (blue && red_keep)) eject_ms = 9'(EJECT_HOLD);
        end
        if (jam_en) begin
          if (reverse_ms == 0 && (lagging(t.top_cmd_speed, t.top_velocity) ||
                                  lagging(t.bottom_cmd_speed, t.bottom_velocity))) begin
            stall_ms = stall_ms + 7'(TICK);
          end else begin
            stall_ms = '0;
          end
          if (stall_ms > STALL_MAX) begin
            reverse_ms = 9'(REVERSE_HOLD);
            stall_ms = '0;
          end
        end
      end else begin
        grace_ms = tick_down(grace_ms);
      end
      if (prev_power == 0 && t.cmd_power > 0) grace_ms = 9'(START_GRACE);
      prev_power = t.cmd_power;
      if (eject_ms != 0) begin
        reverse_ms = 9'd1;
        grace_ms = '0;
        eject_ms = tick_down(eject_ms);
        want.top_drive_mv    = to_mv(SPD_LIM);
        want.bottom_drive_mv = to_mv(t.bottom_cmd_speed);
        want.drive_mode      = MODE_EJECT;
      end else if (reverse_ms != 0) begin
        grace_ms = 9'(RECOVER_GRACE);
        reverse_ms = tick_down(reverse_ms);
        want.top_drive_mv    = to_mv(back_off(t.top_cmd_speed));
        want.bottom_drive_mv = to_mv(back_off(t.bottom_cmd_speed));
        want.drive_mode      = MODE_REVERSE;
      end else begin
        want.top_drive_mv    = to_mv(t.top_cmd_speed);
        want.bottom_drive_mv = to_mv(t.bottom_cmd_speed);
        valve = t.mid_goal_mode;
        want.drive_mode      = MODE_NORMAL;
      end
      want.descore_valve = valve;
      pending_drives.push_back(want);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("drive %0d: %s", drives_seen, what);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) flag($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    function void check_drive(logic [OUT_DATA_W-1:0] data);
      out_item_t got, want;
      got = out_item_t'(data[$bits(out_item_t)-1:0]);
      drives_seen++;
      if (pending_drives.size() == 0) begin
        flag($sformatf("unexpected transaction %h", data));
        return;
      end
      want = pending_drives.pop_front();
      check_field("top_drive_mv", want.top_drive_mv, got.top_drive_mv);
      check_field("bottom_drive_mv", want.bottom_drive_mv, got.bottom_drive_mv);
      check_field("descore_valve", want.descore_valve, got.descore_valve);
      check_field("drive_mode", want.drive_mode, got.drive_mode);
      check_field("tdata pad", 0, data[OUT_DATA_W-1:$bits(out_item_t)]);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = '0;
  logic                  cfg_wdata_i = 1'b0;

  bit                    calm;
  int                    quiet_cycles = 0;
  roller_drive_tracker   tracker;

  intake_jam_and_color_eject_control dut (.*);

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic in_item_t any_tick();
    in_item_t t;
    t.top_cmd_speed    = 12'($urandom);
    t.bottom_cmd_speed = 12'($urandom);
    t.cmd_power        = 12'($urandom);
    t.unloading_mode   = 1'($urandom);
    t.mid_goal_mode    = 1'($urandom);
    t.top_velocity     = 11'($urandom);
    t.bottom_velocity  = 11'($urandom);
    t.hue_deg          = 9'($urandom_range(0, 359));
    t.proximity        = 8'($urandom);
    t.sensor_present   = 1'($urandom);
    return t;
  endfunction

  function automatic in_item_t make_tick(int top, int bot, int pwr, bit unl, bit mid,
                                         int tv, int bv, int hue, int prox, bit pres);
    in_item_t t;
    t.top_cmd_speed    = 12'(top);
    t.bottom_cmd_speed = 12'(bot);
    t.cmd_power        = 12'(pwr);
    t.unloading_mode   = unl;
    t.mid_goal_mode    = mid;
    t.top_velocity     = 11'(tv);
    t.bottom_velocity  = 11'(bv);
    t.hue_deg          = 9'(hue);
    t.proximity        = 8'(prox);
    t.sensor_present   = pres;
    return t;
  endfunction

  function automatic logic signed [11:0] pick_speed();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 12'sd0;
    if (r == 1) return 12'($urandom);
    return 12'(int'($urandom_range(0, 2400)) - 1200);
  endfunction

  function automatic logic signed [10:0] pace_vel(logic signed [11:0] spd, bit slow);
    int s, v;
    s = spd;
    if (slow) v = s / 20;
    else v = s / 10 + ((s < 0) ? -1 : 1) * int'($urandom_range(0, 100));
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return 11'(v);
  endfunction

  function automatic logic [8:0] color_hue();
    case ($urandom_range(0, 3))
      0: return 9'($urandom_range(0, HUE_RED_BELOW - 1));
      1: return 9'($urandom_range(HUE_RED_ABOVE + 1, 359));
      2: return 9'($urandom_range(HUE_BLUE_ABOVE + 1, HUE_BLUE_BELOW - 1));
      default: return 9'($urandom_range(0, 359));
    endcase
  endfunction

  task automatic send_tick(in_item_t t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(t);
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_tick(t);
  endtask

  task automatic write_regs(logic [2:0] plan);
    cfg_reg_e regs[3] = '{CFG_COLOR_SORT, CFG_KEEP_RED, CFG_JAM_RECOVER};
    logic     vals[3] = '{plan[2], plan[1], plan[0]};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_wdata_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_reg(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_segment(output int count);
    in_item_t base, t;
    segment_e seg;
    int       r, len, lead, slow_pick;
    bit       broken;
    r = $urandom_range(0, 19);
    if (r < 7) seg = SEG_STALL;
    else if (r < 11) seg = SEG_RUN;
    else if (r < 15) seg = SEG_COLOR;
    else if (r < 17) seg = SEG_POWER_UP;
    else seg = SEG_NOISE;
    case (seg)
      SEG_STALL:    len = $urandom_range(18, 40);
      SEG_RUN:      len = $urandom_range(4, 30);
      SEG_COLOR:    len = $urandom_range(2, 10);
      SEG_POWER_UP: len = $urandom_range(3, 60);
      default:      len = $urandom_range(2, 20);
    endcase
    calm = ($urandom_range(0, 3) == 0);
    lead = $urandom_range(1, 4);
    slow_pick = $urandom_range(0, 2);
    base = any_tick();
    base.top_cmd_speed    = pick_speed();
    base.bottom_cmd_speed = pick_speed();
    base.cmd_power = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(1, 2047))
                                                 : -12'($urandom_range(1, 2048));
    for (int i = 0; i < len; i++) begin
      t = base;
      t.mid_goal_mode   = 1'($urandom);
      t.top_velocity    = pace_vel(t.top_cmd_speed, 1'b0);
      t.bottom_velocity = pace_vel(t.bottom_cmd_speed, 1'b0);
      case (seg)
        SEG_STALL: begin
          broken = ($urandom_range(0, 15) == 0);
          t.top_velocity    = pace_vel(t.top_cmd_speed, slow_pick != 1 && !broken);
          t.bottom_velocity = pace_vel(t.bottom_cmd_speed, slow_pick != 0 && !broken);
          t.proximity       = 8'($urandom_range(0, PROX_NEAR - 1));
        end
        SEG_RUN: begin
          t.proximity = 8'($urandom);
          t.hue_deg   = 9'($urandom_range(0, 359));
        end
        SEG_COLOR: begin
          t.proximity      = 8'($urandom_range(PROX_NEAR, 255));
          t.hue_deg        = color_hue();
          t.sensor_present = ($urandom_range(0, 7) != 0);
          t.unloading_mode = ($urandom_range(0, 7) == 0);
        end
        SEG_POWER_UP: begin
          t.cmd_power = (i < lead) ? 12'sd0 : 12'($urandom_range(1, 2047));
        end
        default: t = any_tick();
      endcase
      send_tick(t);
    end
    count = len;
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : drive_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      tracker.check_drive(m_axis_tdata);
    end
  end

  initial begin : tick_source
    int sent, count;
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_regs(CFG_PLAN[p]);
      if (p == 0) begin
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(2047, -2048, -2048, 0, 1, 1023, -1024, 359, 255, 0));
        send_tick(make_tick(-2048, 2047, -1, 0, 0, -1024, 1023, 0, 39, 1));
        send_tick(make_tick(1000, -1000, 100, 0, 1, 100, -100, 30, 40, 1));
        send_tick(make_tick(1001, -1001, 100, 0, 0, 101, -101, 340, 40, 1));
        send_tick(make_tick(999, -999, 100, 0, 1, 100, -100, 120, 40, 1));
        send_tick(make_tick(-1, 1, 100, 0, 1, 0, 0, 270, 255, 1));
        send_tick(make_tick(500, 500, 100, 1, 0, 50, 50, 200, 200, 1));
        send_tick(make_tick(500, 500, 100, 0, 0, 50, 50, 121, 40, 1));
        send_tick(make_tick(-2048, 2047, 0, 0, 1, 0, 0, 0, 0, 0));
        send_tick(make_tick(-5, -2048, 2047, 0, 1, 0, 0, 269, 40, 1));
      end
      sent = 0;
      while (sent < PHASE_TICKS) begin
        run_segment(count);
        sent += count;
      end
      s_axis_tvalid <= 1'b0;
      while (tracker.pending_drives.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end
    if (tracker.mismatches == 0 && tracker.pending_drives.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
